>>> design/fhwd_pkg.sv
// Package for the flex hold word detector: channel count, widths, codes
// and the lane status record shared by the lane, merge and top modules.
// No dependencies.
package fhwd_pkg;

   localparam int CHANNELS  = 3;
   localparam int SAMPLE_W  = 12;
   localparam int TIME_W    = 32;
   localparam int HOLD_W    = 16;
   localparam int OWNER_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 16;

   localparam logic [OWNER_W-1:0] NO_OWNER = 2'd3;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FLEX_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME_MS   = 2'd1;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd4000;
   localparam logic [HOLD_W-1:0]   HOLD_RESET      = 16'd1000;

   // what one lane reports to the merge stage for the current transfer
   typedef struct packed {
      logic bent;        // sample at or above threshold
      logic fire_ready;  // timer running, not yet fired, hold time reached
   } lane_status_type;

endpackage

>>> design/flex_hold_word_detector.sv
// Top level of the flex hold word detector: stream ports, configuration
// registers, channel lanes, merge stage and result register.
// Depends on fhwd_pkg, fhwd_lane and fhwd_merge.
// Usage:
//   req_* carries one sample set per transfer: three 12-bit flex samples and
//   a 32-bit millisecond timestamp. rsp_* returns exactly one result per
//   sample set: a fired flag in tuser, the firing channel and the channel
//   holding the turn in tdata.
//   The result of a set accepted at one edge is shown in the result
//   register from the next cycle. Throughput is one set per cycle while
//   the result register is free or being emptied; the lanes compare and
//   time all channels at once and the merge turn walk settles in that cycle.
//   When the receiver stalls, the result register holds its content and
//   req_tready is high only while that register is empty or is being emptied
//   in the same cycle, so a held result is never overwritten.
//   Reset (synchronous) clears all hold timers and fired marks, frees the
//   turn, sets threshold to 4000 and hold time to 1000 ms, and empties the
//   result register.
//   Configuration writes (csr_we) take effect at the next edge; indexes
//   beyond the two registers are ignored.
module flex_hold_word_detector
   import fhwd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // sample set channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // tdata: flex_sample_0[11:0], flex_sample_1[23:12], flex_sample_2[35:24],
   //        now_ms[67:36], zero fill[71:68]
   input  logic [71:0]          req_tdata,
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // tdata: word_index[1:0], turn_owner[3:2], zero fill[7:4]
   output logic [7:0]           rsp_tdata,
   // tuser: word_fired[0]
   output logic                 rsp_tuser,
   // configuration write port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [SAMPLE_W-1:0] threshold_ff;
   logic [HOLD_W-1:0]   hold_time_ff;
   logic                accept;
   logic [TIME_W-1:0]   now_ms;
   lane_status_type     status [CHANNELS];
   logic [CHANNELS-1:0] grant;
   logic                word_fired;
   logic [OWNER_W-1:0]  word_index;
   logic [OWNER_W-1:0]  turn_owner;
   logic                rsp_valid_ff;
   logic                rsp_fired_ff;
   logic [OWNER_W-1:0]  rsp_index_ff;
   logic [OWNER_W-1:0]  rsp_owner_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         hold_time_ff <= HOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FLEX_THRESHOLD: threshold_ff <= csr_wdata[SAMPLE_W-1:0];
            CSR_HOLD_TIME_MS:   hold_time_ff <= csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: take a new set whenever the result register frees up
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign now_ms     = req_tdata[CHANNELS*SAMPLE_W +: TIME_W];

   // channel lanes
   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      fhwd_lane u_lane (
         .clock          (clock),
         .reset          (reset),
         .accept         (accept),
         .sample         (req_tdata[c*SAMPLE_W +: SAMPLE_W]),
         .now_ms         (now_ms),
         .flex_threshold (threshold_ff),
         .hold_time_ms   (hold_time_ff),
         .grant          (grant[c]),
         .status         (status[c])
      );
   end

   fhwd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .status     (status),
      .grant      (grant),
      .word_fired (word_fired),
      .word_index (word_index),
      .turn_owner (turn_owner)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_fired_ff <= word_fired;
         rsp_index_ff <= word_index;
         rsp_owner_ff <= turn_owner;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_fired_ff;
   assign rsp_tdata  = {4'b0000, rsp_owner_ff, rsp_index_ff};

   // every accepted set shows a result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted set produced no result");

   // a firing channel still holds the turn at the end of the step
   a_fire_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_index_ff == rsp_owner_ff)
      else $error("fired channel does not hold the turn");

endmodule

>>> design/fhwd_lane.sv
// One channel lane: bend compare, hold timer and fired mark.
// Depends on fhwd_pkg.
module fhwd_lane
   import fhwd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [TIME_W-1:0]   now_ms,
   input  logic [SAMPLE_W-1:0] flex_threshold,
   input  logic [HOLD_W-1:0]   hold_time_ms,
   input  logic                grant,
   output lane_status_type     status
);

   logic [TIME_W-1:0] hold_start_ff, hold_start_in;
   logic              active_ff, active_in;
   logic              fired_ff, fired_in;
   logic [TIME_W-1:0] elapsed;

   // elapsed time wraps modulo 2^32
   assign elapsed           = now_ms - hold_start_ff;
   assign status.bent       = (sample >= flex_threshold);
   assign status.fire_ready = active_ff && !fired_ff &&
                              (elapsed >= {{(TIME_W-HOLD_W){1'b0}}, hold_time_ms});

   // timer and fired mark update
   always_comb begin
      hold_start_in = hold_start_ff;
      active_in     = active_ff;
      fired_in      = fired_ff;
      if (!status.bent) begin
         hold_start_in = '0;
         active_in     = 1'b0;
         fired_in      = 1'b0;
      end else if (grant) begin
         if (!active_ff) begin
            active_in     = 1'b1;
            hold_start_in = now_ms;
         end else if (status.fire_ready) begin
            fired_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         fired_ff  <= 1'b0;
      end else if (accept) begin
         active_ff <= active_in;
         fired_ff  <= fired_in;
      end
   end

   // start time is only read while the timer runs
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_start_ff <= hold_start_in;
      end
   end

endmodule

>>> design/fhwd_merge.sv
// Merge stage: walks the turn through the lanes in channel order, grants
// lanes, picks the firing channel and keeps the turn owner register.
// Depends on fhwd_pkg.
module fhwd_merge
   import fhwd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  lane_status_type       status [CHANNELS],
   output logic [CHANNELS-1:0]   grant,
   output logic                  word_fired,
   output logic [OWNER_W-1:0]    word_index,
   output logic [OWNER_W-1:0]    turn_owner
);

   logic [OWNER_W-1:0]  owner_ff, owner_in;
   logic [CHANNELS-1:0] fire;

   // turn passes through the channels in order 0 upwards
   always_comb begin
      owner_in   = owner_ff;
      word_fired = 1'b0;
      word_index = '0;
      grant      = '0;
      fire       = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (status[c].bent) begin
            if (owner_in == NO_OWNER || owner_in == OWNER_W'(c)) begin
               grant[c] = 1'b1;
               owner_in = OWNER_W'(c);
               if (status[c].fire_ready) begin
                  fire[c]    = 1'b1;
                  word_fired = 1'b1;
                  word_index = OWNER_W'(c);
               end
            end
         end else if (owner_in == OWNER_W'(c)) begin
            owner_in = NO_OWNER;
         end
      end
   end

   assign turn_owner = owner_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff <= NO_OWNER;
      end else if (accept) begin
         owner_ff <= owner_in;
      end
   end

   // only the turn holder may fire, so at most one lane fires
   a_one_fire: assert property (@(posedge clock) disable iff (reset)
      $onehot0(fire))
      else $error("more than one lane fired");

   a_fire_granted: assert property (@(posedge clock) disable iff (reset)
      (fire & ~grant) == '0)
      else $error("lane fired without the turn");

   a_owner_code: assert property (@(posedge clock) disable iff (reset)
      owner_ff == NO_OWNER || owner_ff < OWNER_W'(CHANNELS))
      else $error("turn owner out of range");

endmodule
